FILE: hdl/dsrm_pkg.sv
// shared constants and types for the dot-star pattern matcher
package dsrm_pkg;

   localparam int PATTERN_MAX = 32;
   localparam int PAT_WORDS = 4;
   localparam int WORD_W = 64;
   localparam int LEN_W = 6;
   localparam int CSR_IDX_W = 3;
   localparam int N_W = $clog2(PATTERN_MAX + 1);

   localparam logic [7:0] DOT_CHAR = 8'h2E;
   localparam logic [7:0] STAR_CHAR = 8'h2A;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd4;

   // broadcast to every cell each cycle
   typedef struct packed {
      logic       accept;
      logic       restart;
      logic       has_byte;
      logic [7:0] text_byte;
   } step_type;

   // static pattern view of one position
   typedef struct packed {
      logic [7:0] tok_byte;
      logic [7:0] next_byte;
      logic       tok_live;
      logic       star_live;
      logic       in_range;
   } pos_type;

   // handed from a cell to the cells after it
   typedef struct packed {
      logic skip_pre;
      logic skip_post;
      logic advance;
   } link_type;

endpackage

FILE: hdl/dsrm_cell.sv
// one pattern position: active bit, star skips and byte advance
module dsrm_cell
   import dsrm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start_pos,
   input  step_type step,
   input  pos_type  pos,
   input  link_type prev1,
   input  link_type prev2,
   output link_type link,
   output logic     result
);

   logic active_ff;
   logic active_in;
   logic starred;
   logic hit;
   logic closed_pre;
   logic next_v;
   logic closed_post;

   always_comb begin
      starred = pos.star_live && (pos.next_byte == STAR_CHAR);
      hit = pos.tok_live && ((pos.tok_byte == step.text_byte) || (pos.tok_byte == DOT_CHAR));
      // closure of the held set, skips ripple in from two cells back
      closed_pre = (active_ff && pos.in_range) || prev2.skip_pre;
      link.skip_pre = closed_pre && starred;
      link.advance = closed_pre && hit && !starred;
      next_v = (closed_pre && hit && starred) || prev1.advance;
      closed_post = next_v || prev2.skip_post;
      link.skip_post = closed_post && starred;
      result = step.has_byte ? closed_post : closed_pre;
      active_in = active_ff;
      if (step.accept) begin
         active_in = step.restart ? start_pos : result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= start_pos;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

FILE: hdl/dot_star_regex_matcher.sv
// top level: pattern registers, row of position cells, result register
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | text_byte, has_byte, end_of_text
//  rsp     | out       | rsp_valid/ready    | whole_match, can_still_match, text_ended
//  csr     | in        | csr_write_enable   | csr_index, csr_write_data
//
// one request per cycle unless a response is held; its response is registered and shows in the cycle after acceptance.
// the star-skip closure ripples through the cell row combinationally, in the cycle of acceptance.
// reset clears the pattern, sets length zero and leaves only position 0 active.
// a held response takes req_ready low only while rsp_ready is low.
module dot_star_regex_matcher
   import dsrm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_text_byte,
   input  logic                 req_has_byte,
   input  logic                 req_end_of_text,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_whole_match,
   output logic                 rsp_can_still_match,
   output logic                 rsp_text_ended,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_write_data
);

   logic [WORD_W-1:0] pat_words_ff [PAT_WORDS];
   logic [WORD_W-1:0] pat_words_in [PAT_WORDS];
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic [N_W-1:0]    used_len;

   logic [7:0]        pat_byte [PATTERN_MAX+1];
   logic [PATTERN_MAX:0] tok_live;
   pos_type           pos [PATTERN_MAX+1];
   link_type          links [PATTERN_MAX+1];
   logic [PATTERN_MAX:0] results;
   step_type          step;

   logic rsp_valid_ff, rsp_valid_in;
   logic whole_ff, whole_in;
   logic any_ff, any_in;
   logic ended_ff, ended_in;
   logic accept;

   // configuration writes
   always_comb begin
      for (int w = 0; w < PAT_WORDS; w++) begin
         pat_words_in[w] = pat_words_ff[w];
      end
      len_in = len_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_0:      pat_words_in[0] = csr_write_data;
            CSR_PATTERN_1:      pat_words_in[1] = csr_write_data;
            CSR_PATTERN_2:      pat_words_in[2] = csr_write_data;
            CSR_PATTERN_3:      pat_words_in[3] = csr_write_data;
            CSR_PATTERN_LENGTH: len_in = csr_write_data[LEN_W-1:0];
            default:            len_in = len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < PAT_WORDS; w++) begin
            pat_words_ff[w] <= '0;
         end
         len_ff <= '0;
      end else begin
         pat_words_ff <= pat_words_in;
         len_ff <= len_in;
      end
   end

   always_comb begin
      if (int'(len_ff) > PATTERN_MAX) begin
         used_len = N_W'(PATTERN_MAX);
      end else begin
         used_len = N_W'(len_ff);
      end
   end

   assign accept = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      step.accept = accept;
      step.restart = req_end_of_text;
      step.has_byte = req_has_byte;
      step.text_byte = req_text_byte;
   end

   genvar j;
   generate
      for (j = 0; j <= PATTERN_MAX; j++) begin : g_pos
         // bytes past the register file read as zero
         if (j < PAT_WORDS * 8 && j < PATTERN_MAX) begin : g_byte
            assign pat_byte[j] = pat_words_ff[j / 8][8 * (j % 8) +: 8];
         end else begin : g_zero
            assign pat_byte[j] = 8'h00;
         end

         assign tok_live[j] = used_len > N_W'(j);

         always_comb begin
            pos[j].tok_byte = pat_byte[j];
            pos[j].tok_live = tok_live[j];
            pos[j].in_range = used_len >= N_W'(j);
            if (j < PATTERN_MAX) begin
               pos[j].next_byte = pat_byte[(j < PATTERN_MAX) ? j + 1 : j];
               pos[j].star_live = tok_live[(j < PATTERN_MAX) ? j + 1 : j];
            end else begin
               pos[j].next_byte = 8'h00;
               pos[j].star_live = 1'b0;
            end
         end

         if (j == 0) begin : g_first
            dsrm_cell u_cell (
               .clock  (clock),
               .reset  (reset),
               .start_pos (1'b1),
               .step   (step),
               .pos    (pos[j]),
               .prev1  ('0),
               .prev2  ('0),
               .link   (links[j]),
               .result (results[j])
            );
         end else if (j == 1) begin : g_second
            dsrm_cell u_cell (
               .clock  (clock),
               .reset  (reset),
               .start_pos (1'b0),
               .step   (step),
               .pos    (pos[j]),
               .prev1  (links[j-1]),
               .prev2  ('0),
               .link   (links[j]),
               .result (results[j])
            );
         end else begin : g_rest
            dsrm_cell u_cell (
               .clock  (clock),
               .reset  (reset),
               .start_pos (1'b0),
               .step   (step),
               .pos    (pos[j]),
               .prev1  (links[j-1]),
               .prev2  (links[j-2]),
               .link   (links[j]),
               .result (results[j])
            );
         end
      end
   endgenerate

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      whole_in = whole_ff;
      any_in = any_ff;
      ended_in = ended_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         whole_in = results[used_len];
         any_in = |results;
         ended_in = req_end_of_text;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      whole_ff <= whole_in;
      any_ff <= any_in;
      ended_ff <= ended_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_whole_match = whole_ff;
   assign rsp_can_still_match = any_ff;
   assign rsp_text_ended = ended_ff;

endmodule

FILE: hdl/dsrm_checker.sv
// port-level checks for the matcher, bound to the top level
module dsrm_checker
   import dsrm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_whole_match,
   input logic rsp_can_still_match,
   input logic rsp_text_ended
);

   // a full match means some position is still active
   a_match_implies_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_whole_match || rsp_can_still_match))
      else $error("whole match without a live position");

   // every accepted request gives a response in the next cycle
   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request gave no response");

   // a held response blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while response held");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_whole_match)
         && $stable(rsp_can_still_match) && $stable(rsp_text_ended)))
      else $error("held response changed");

endmodule

bind dot_star_regex_matcher dsrm_checker u_dsrm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_whole_match     (rsp_whole_match),
   .rsp_can_still_match (rsp_can_still_match),
   .rsp_text_ended      (rsp_text_ended)
);
